>>> sv/bkls_pkg.sv
`default_nettype none

package bkls_pkg;

   localparam int DEF_MAX_PERMS      = 256;
   localparam int DEF_MAX_LABELS     = 64;
   localparam int DEF_WORDS_PER_SLOT = 8;
   localparam int DEF_WORD_BITS      = 32;

   localparam int NL_W       = 7;
   localparam int NC_W       = 5;
   localparam int DPW_W      = 6;
   localparam int NP_W       = 9;
   localparam int SLOT_W     = 8;
   localparam int LABEL_W    = 4;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // quotient bits resolved per divider cycle
   localparam int DIV_BITS = 4;

   localparam logic [NL_W-1:0]  RST_NUM_LABELS      = 7'd64;
   localparam logic [NC_W-1:0]  RST_NUM_CLASSES     = 5'd2;
   localparam logic [DPW_W-1:0] RST_DIGITS_PER_WORD = 6'd32;
   localparam logic [NP_W-1:0]  RST_NUM_PERMS       = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LABELS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_PER_WORD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PERMS       = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_READ       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_WRITE_DONE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_SLOT   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ERR,
      ST_WRITE,
      ST_WR_RESP,
      ST_RD_ADDR,
      ST_RD_LOAD,
      ST_RD_DIV,
      ST_RD_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> sv/base_k_label_pack_store.sv
// Packed store of class-label vectors. Each slot holds num_labels labels packed as base-k
// digits (k = num_classes), digits_per_word to a WORD_BITS-bit word, lowest digit first. A
// write word carries one label; the stream for a vector packs labels into an accumulator
// and stores each finished word into the slot named by the write that finishes it, and
// after the last label one completion word (status 1) is returned. A read word unpacks a
// whole slot and returns one word per label (status 0), last set on the final label. A slot
// at or beyond num_perms returns a single status 2 word and leaves the stream untouched.
// Reading a slot that was never written returns unspecified labels. A write label passes
// through dispatch and the write step before the next is accepted, the last label of a
// vector also through the completion step, an out-of-range slot through dispatch and
// the error step. A read passes through dispatch, then per word the address and load
// steps of the registered memory fetch, and per label the divider steps (4 quotient
// bits per cycle) and the emit step. A stalled result port adds its stall cycles to the
// step that loads the result. The result register lets a new word be accepted while the
// final result of the previous one is still waiting. Configuration is to be written only
// while idle, which the store does not enforce; it has no clearing pass after reset.

`default_nettype none

module base_k_label_pack_store
   import bkls_pkg::*;
#(
   parameter int MAX_PERMS      = DEF_MAX_PERMS,
   parameter int MAX_LABELS     = DEF_MAX_LABELS,
   parameter int WORDS_PER_SLOT = DEF_WORDS_PER_SLOT,
   parameter int WORD_BITS      = DEF_WORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_type,
   input  wire logic [SLOT_W-1:0]     req_perm_index,
   input  wire logic [LABEL_W-1:0]    req_label,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [LABEL_W-1:0]    rsp_label_out,
   output      logic [POS_W-1:0]      rsp_position,
   output      logic                  rsp_last,
   output      logic [STATUS_W-1:0]   rsp_status,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH      = MAX_PERMS * WORDS_PER_SLOT;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int WS_W       = $clog2(WORDS_PER_SLOT + 1);
   localparam int LW_W       = $clog2(MAX_LABELS + 1);
   localparam int DIV_CYCLES = (WORD_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int QW         = DIV_CYCLES * DIV_BITS;
   localparam int DCYC_W     = $clog2(DIV_CYCLES);
   localparam int REM_W      = NC_W;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                                 input logic [31:0] word);
      logic [31:0] full;
      full = 32'(slot) * 32'(WORDS_PER_SLOT) + word;
      return full[ADDR_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [NL_W-1:0]  num_labels_ff;
   logic [NC_W-1:0]  num_classes_ff;
   logic [DPW_W-1:0] digits_per_word_ff;
   logic [NP_W-1:0]  num_perms_ff;

   logic                  req_type_ff, req_type_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [LABEL_W-1:0]    label_ff, label_in;

   logic [WORD_BITS-1:0]  acc_ff, acc_in;
   logic [WORD_BITS-1:0]  weight_ff, weight_in;
   logic [DPW_W-1:0]      dc_ff, dc_in;
   logic [WS_W-1:0]       ws_ff, ws_in;
   logic [LW_W-1:0]       lw_ff, lw_in;

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [LW_W-1:0]       rw_ff, rw_in;
   logic [DPW_W-1:0]      rdc_ff, rdc_in;
   logic [QW-1:0]         val_ff, val_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DCYC_W-1:0]     dcyc_ff, dcyc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]    rsp_label_ff, rsp_label_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [WORD_BITS-1:0]  packed_words_ff [DEPTH];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [WORD_BITS-1:0]  mem_wdata;

   logic [NL_W-1:0]       n_eff;
   logic [NC_W-1:0]       k_eff;
   logic [DPW_W-1:0]      dpw_eff;
   logic                  slot_ok;
   logic                  out_free;

   logic [WORD_BITS+3:0]  lab_prod;
   logic [WORD_BITS+4:0]  wgt_prod;
   logic [WORD_BITS-1:0]  acc_sum;
   logic [DPW_W-1:0]      dc_next;
   logic [LW_W-1:0]       lw_next;
   logic                  lw_done;
   logic                  word_done;
   logic                  ws_room;
   logic                  rw_room;
   logic                  last_lab;
   logic                  word_end;

   logic [QW-1:0]         div_q;
   logic [REM_W-1:0]      div_r;

   // effective configuration
   always_comb begin
      if (num_labels_ff == '0) begin
         n_eff = NL_W'(1);
      end else if (num_labels_ff > NL_W'(MAX_LABELS)) begin
         n_eff = NL_W'(MAX_LABELS);
      end else begin
         n_eff = num_labels_ff;
      end
      k_eff   = (num_classes_ff < NC_W'(2)) ? NC_W'(2) : num_classes_ff;
      dpw_eff = (digits_per_word_ff == '0) ? DPW_W'(1) : digits_per_word_ff;
   end

   assign slot_ok  = (NP_W'(slot_ff) < num_perms_ff) && (32'(slot_ff) < 32'(MAX_PERMS));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // write datapath
   assign lab_prod  = (WORD_BITS + 4)'(label_ff) * (WORD_BITS + 4)'(weight_ff);
   assign wgt_prod  = (WORD_BITS + 5)'(weight_ff) * (WORD_BITS + 5)'(k_eff);
   assign acc_sum   = acc_ff + lab_prod[WORD_BITS-1:0];
   assign dc_next   = dc_ff + DPW_W'(1);
   assign lw_next   = lw_ff + LW_W'(1);
   assign lw_done   = NL_W'(lw_next) >= n_eff;
   assign word_done = (dc_next >= dpw_eff) || lw_done;
   assign ws_room   = 32'(ws_ff) < 32'(WORDS_PER_SLOT);

   // read bookkeeping
   assign rw_room  = 32'(rw_ff) < 32'(WORDS_PER_SLOT);
   assign last_lab = (NL_W'(pos_ff) + NL_W'(1)) == n_eff;
   assign word_end = (rdc_ff + DPW_W'(1)) >= dpw_eff;

   // shared divider, DIV_BITS restoring steps per cycle
   always_comb begin
      logic [QW-1:0]    q;
      logic [REM_W:0]   r;
      q = val_ff;
      r = (REM_W + 1)'(rem_ff);
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[REM_W-1:0], q[QW-1]};
         q = {q[QW-2:0], 1'b0};
         if (r >= (REM_W + 1)'(k_eff)) begin
            r    = r - (REM_W + 1)'(k_eff);
            q[0] = 1'b1;
         end
      end
      div_q = q;
      div_r = r[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      slot_in       = slot_ff;
      label_in      = label_ff;
      acc_in        = acc_ff;
      weight_in     = weight_ff;
      dc_in         = dc_ff;
      ws_in         = ws_ff;
      lw_in         = lw_ff;
      pos_in        = pos_ff;
      rw_in         = rw_ff;
      rdc_in        = rdc_ff;
      val_in        = val_ff;
      rem_in        = rem_ff;
      dcyc_in       = dcyc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_label_in  = rsp_label_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_of(slot_ff, 32'(ws_ff));
      mem_wdata     = acc_sum;
      mem_raddr     = addr_of(slot_ff, 32'(rw_ff));
      req_stall     = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_type_in = req_type;
               slot_in     = req_perm_index;
               label_in    = req_label;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!slot_ok) begin
               state_in = ST_ERR;
            end else if (req_type_ff == REQ_WRITE) begin
               state_in = ST_WRITE;
            end else begin
               pos_in   = '0;
               rw_in    = '0;
               rdc_in   = '0;
               state_in = ST_RD_ADDR;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_label_in  = '0;
               rsp_pos_in    = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = STAT_BAD_SLOT;
               state_in      = ST_IDLE;
            end
         end
         ST_WRITE: begin
            if (word_done) begin
               mem_we    = ws_room;
               acc_in    = '0;
               weight_in = WORD_BITS'(1);
               dc_in     = '0;
               if (ws_room) begin
                  ws_in = ws_ff + WS_W'(1);
               end
            end else begin
               acc_in    = acc_sum;
               weight_in = wgt_prod[WORD_BITS-1:0];
               dc_in     = dc_next;
            end
            if (lw_done) begin
               ws_in    = '0;
               lw_in    = '0;
               state_in = ST_WR_RESP;
            end else begin
               lw_in    = lw_next;
               state_in = ST_IDLE;
            end
         end
         ST_WR_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_label_in  = '0;
               rsp_pos_in    = POS_W'(n_eff - NL_W'(1));
               rsp_last_in   = 1'b1;
               rsp_status_in = STAT_WRITE_DONE;
               state_in      = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_LOAD;
         end
         ST_RD_LOAD: begin
            val_in   = rw_room ? QW'(rd_data_ff) : '0;
            rem_in   = '0;
            dcyc_in  = '0;
            state_in = ST_RD_DIV;
         end
         ST_RD_DIV: begin
            val_in  = div_q;
            rem_in  = div_r;
            dcyc_in = dcyc_ff + DCYC_W'(1);
            if (dcyc_ff == DCYC_W'(DIV_CYCLES - 1)) begin
               state_in = ST_RD_EMIT;
            end
         end
         ST_RD_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_label_in  = rem_ff[LABEL_W-1:0];
               rsp_pos_in    = pos_ff;
               rsp_last_in   = last_lab;
               rsp_status_in = STAT_READ;
               pos_in        = pos_ff + POS_W'(1);
               if (last_lab) begin
                  state_in = ST_IDLE;
               end else if (word_end) begin
                  rdc_in   = '0;
                  rw_in    = rw_ff + LW_W'(1);
                  state_in = ST_RD_ADDR;
               end else begin
                  rdc_in   = rdc_ff + DPW_W'(1);
                  rem_in   = '0;
                  dcyc_in  = '0;
                  state_in = ST_RD_DIV;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_labels_ff      <= RST_NUM_LABELS;
         num_classes_ff     <= RST_NUM_CLASSES;
         digits_per_word_ff <= RST_DIGITS_PER_WORD;
         num_perms_ff       <= RST_NUM_PERMS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_LABELS:      num_labels_ff      <= csr_data[NL_W-1:0];
            CSR_NUM_CLASSES:     num_classes_ff     <= csr_data[NC_W-1:0];
            CSR_DIGITS_PER_WORD: digits_per_word_ff <= csr_data[DPW_W-1:0];
            CSR_NUM_PERMS:       num_perms_ff       <= csr_data[NP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         weight_ff    <= WORD_BITS'(1);
         dc_ff        <= '0;
         ws_ff        <= '0;
         lw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         weight_ff    <= weight_in;
         dc_ff        <= dc_in;
         ws_ff        <= ws_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      slot_ff       <= slot_in;
      label_ff      <= label_in;
      pos_ff        <= pos_in;
      rw_ff         <= rw_in;
      rdc_ff        <= rdc_in;
      val_ff        <= val_in;
      rem_ff        <= rem_in;
      dcyc_ff       <= dcyc_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         packed_words_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= packed_words_ff[mem_raddr];
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_label_out = rsp_label_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

   // divider remainder is a proper digit when it is shown
   a_rem_below_k: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_EMIT |-> rem_ff < k_eff)
      else $error("remainder not below radix");

   // final read label sits at the end of the vector
   a_read_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_READ && rsp_last_ff
      |-> (NL_W'(rsp_pos_ff) + NL_W'(1)) == n_eff)
      else $error("last read label at wrong position");

   // store writes only from the write step, within the slot
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_WRITE && ws_room && slot_ok)
      else $error("unexpected store write");

   // a stored word is followed by a fresh accumulator
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> acc_ff == '0 && dc_ff == '0)
      else $error("accumulator not cleared after store");

endmodule

`default_nettype wire

>>> verif/tb_base_k_label_pack_store.sv
`timescale 1ns / 100ps

module tb_base_k_label_pack_store
   import bkls_pkg::*;
();

   localparam int WB            = DEF_WORD_BITS;
   localparam int WPS           = DEF_WORDS_PER_SLOT;
   localparam int STORE_DEPTH   = DEF_MAX_PERMS * DEF_WORDS_PER_SLOT;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 4000;
   localparam int RAND_ITEMS    = 500;

   typedef struct packed {
      logic [LABEL_W-1:0]  label;
      logic [POS_W-1:0]    pos;
      logic                last;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   typedef struct {
      bit                    is_cfg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  rtype;
      logic [SLOT_W-1:0]     slot;
      logic [LABEL_W-1:0]    lab;
      bit                    typed;
      rsp_word_type          want;
   } script_row_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_type       = REQ_WRITE;
   logic [SLOT_W-1:0]     req_perm_index = '0;
   logic [LABEL_W-1:0]    req_label      = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [LABEL_W-1:0]    rsp_label_out;
   logic [POS_W-1:0]      rsp_position;
   logic                  rsp_last;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_data       = '0;

   base_k_label_pack_store uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_perm_index (req_perm_index),
      .req_label      (req_label),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_label_out  (rsp_label_out),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // predictor state
   logic [NL_W-1:0]  cfg_labels  = RST_NUM_LABELS;
   logic [NC_W-1:0]  cfg_classes = RST_NUM_CLASSES;
   logic [DPW_W-1:0] cfg_dpw     = RST_DIGITS_PER_WORD;
   logic [NP_W-1:0]  cfg_perms   = RST_NUM_PERMS;
   logic [WB-1:0]    packed_mem [STORE_DEPTH];
   bit               written_mem [STORE_DEPTH];
   logic [WB-1:0]    pack_acc     = '0;
   logic [WB-1:0]    digit_weight = 1;
   int unsigned      digit_count    = 0;
   int unsigned      word_slot      = 0;
   int unsigned      labels_written = 0;

   rsp_word_type      expected_words [$];
   script_row_type    script [$];
   logic [SLOT_W-1:0] stream_slot = '0;
   bit                calm        = 1'b0;
   int unsigned       fail_count  = 0;
   int unsigned       quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_word_type mk_word(input int unsigned l, input int unsigned p,
                                            input logic lst, input logic [STATUS_W-1:0] st);
      rsp_word_type r;
      r.label  = l[LABEL_W-1:0];
      r.pos    = p[POS_W-1:0];
      r.last   = lst;
      r.status = st;
      return r;
   endfunction

   function automatic int unsigned eff_labels();
      if (cfg_labels == 0) return 1;
      if (cfg_labels > DEF_MAX_LABELS) return DEF_MAX_LABELS;
      return cfg_labels;
   endfunction

   function automatic int unsigned eff_dpw();
      return (cfg_dpw == 0) ? 1 : cfg_dpw;
   endfunction

   function automatic bit slot_ok(input logic [SLOT_W-1:0] slot);
      return ({1'b0, slot} < cfg_perms);
   endfunction

   function automatic bit readable(input logic [SLOT_W-1:0] slot);
      int unsigned words;
      int unsigned w;
      if (!slot_ok(slot)) return 1'b0;
      words = (eff_labels() + eff_dpw() - 1) / eff_dpw();
      if (words > WPS) words = WPS;
      for (w = 0; w < words; w++)
         if (!written_mem[slot * WPS + w]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void pack_predict(input logic rtype, input logic [SLOT_W-1:0] slot,
                                        input logic [LABEL_W-1:0] lab);
      int unsigned n;
      int unsigned k;
      int unsigned dpw;
      int unsigned pos;
      int unsigned d;
      int unsigned w;
      logic [63:0] wide;
      logic [63:0] val;
      n   = eff_labels();
      dpw = eff_dpw();
      k   = (cfg_classes < 2) ? 2 : cfg_classes;
      if (!slot_ok(slot)) begin
         expected_words.push_back(mk_word(0, 0, 1'b1, STAT_BAD_SLOT));
         return;
      end
      if (rtype == REQ_WRITE) begin
         wide = 64'(pack_acc);
         wide = wide + lab * digit_weight;
         pack_acc = wide[WB-1:0];
         wide = 64'(digit_weight);
         wide = wide * k;
         digit_weight = wide[WB-1:0];
         digit_count++;
         labels_written++;
         if (digit_count >= dpw || labels_written >= n) begin
            if (word_slot < WPS) begin
               packed_mem[slot * WPS + word_slot]  = pack_acc;
               written_mem[slot * WPS + word_slot] = 1'b1;
               word_slot++;
            end
            pack_acc     = '0;
            digit_weight = 1;
            digit_count  = 0;
         end
         if (labels_written >= n) begin
            word_slot      = 0;
            labels_written = 0;
            expected_words.push_back(mk_word(0, n - 1, 1'b1, STAT_WRITE_DONE));
         end
         return;
      end
      pos = 0;
      w   = 0;
      while (pos < n) begin
         val = (w < WPS) ? packed_mem[slot * WPS + w] : 64'd0;
         for (d = 0; d < dpw && pos < n; d++) begin
            expected_words.push_back(mk_word(32'(val % k), pos, (pos + 1 == n), STAT_READ));
            val = val / k;
            pos++;
         end
         w++;
      end
   endfunction

   task automatic flag_error(input bit unexpected, input rsp_word_type want,
                             input rsp_word_type got);
      fail_count++;
      if (fail_count <= 10) begin
         if (unexpected)
            $display("%0t: unexpected word label=%0d pos=%0d last=%0d status=%0d", $realtime,
                     got.label, got.pos, got.last, got.status);
         else
            $display("%0t: mismatch exp label=%0d pos=%0d last=%0d status=%0d, got %0d %0d %0d %0d",
                     $realtime, want.label, want.pos, want.last, want.status,
                     got.label, got.pos, got.last, got.status);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = mk_word(rsp_label_out, rsp_position, rsp_last, rsp_status);
            if (expected_words.size() == 0) begin
               flag_error(1'b1, got, got);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) flag_error(1'b0, want, got);
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 17);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_req(input logic rtype, input logic [SLOT_W-1:0] slot,
                           input logic [LABEL_W-1:0] lab, input bit typed,
                           input rsp_word_type want);
      int unsigned held;
      if (!calm && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= rtype;
      req_perm_index <= slot;
      req_label      <= lab;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      held = expected_words.size();
      pack_predict(rtype, slot, lab);
      if (typed) begin
         while (expected_words.size() > held) void'(expected_words.pop_back());
         expected_words.push_back(want);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NUM_LABELS:      cfg_labels  = data[NL_W-1:0];
         CSR_NUM_CLASSES:     cfg_classes = data[NC_W-1:0];
         CSR_DIGITS_PER_WORD: cfg_dpw     = data[DPW_W-1:0];
         CSR_NUM_PERMS:       cfg_perms   = data[NP_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      script_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.idx    = idx;
      r.data   = data;
      script.push_back(r);
   endfunction

   function automatic void req_row(input logic rtype, input logic [SLOT_W-1:0] slot,
                                   input logic [LABEL_W-1:0] lab, input bit typed,
                                   input rsp_word_type want);
      script_row_type r;
      r = '{default: '0};
      r.rtype = rtype;
      r.slot  = slot;
      r.lab   = lab;
      r.typed = typed;
      r.want  = want;
      script.push_back(r);
   endfunction

   task automatic phase_config(input int unsigned ph);
      logic [CSR_DATA_W-1:0] n;
      logic [CSR_DATA_W-1:0] k;
      logic [CSR_DATA_W-1:0] d;
      logic [CSR_DATA_W-1:0] p;
      longint unsigned       pw;
      case (ph)
         0: begin n = 64;  k = 2;  d = 32; p = 256; end
         1: begin n = 64;  k = 16; d = 1;  p = 3;   end
         2: begin n = 1;   k = 16; d = 8;  p = 1;   end
         3: begin n = 127; k = 31; d = 63; p = 511; end
         4: begin n = 0;   k = 1;  d = 0;  p = 200; end
         default: begin
            n = ($urandom_range(0, 99) < 70) ? CSR_DATA_W'($urandom_range(1, 12))
                                              : CSR_DATA_W'($urandom_range(13, 64));
            k = CSR_DATA_W'($urandom_range(2, 16));
            if ($urandom_range(0, 1)) begin
               // densest packing that fits a word
               d  = 0;
               pw = k;
               while (pw <= 64'h1_0000_0000) begin
                  d++;
                  pw = pw * k;
               end
            end else begin
               d = CSR_DATA_W'($urandom_range(1, 32));
            end
            p = ($urandom_range(0, 99) < 30) ? CSR_DATA_W'($urandom_range(1, 8))
                                              : CSR_DATA_W'($urandom_range(1, 256));
            if ($urandom_range(0, 19) == 0) p = 0;
            if ($urandom_range(0, 3) == 0) begin
               n[8:7] = 2'($urandom);
               k[8:5] = 4'($urandom);
               d[8:6] = 3'($urandom);
            end
         end
      endcase
      csr_write(CSR_NUM_LABELS, n);
      csr_write(CSR_NUM_CLASSES, k);
      csr_write(CSR_DIGITS_PER_WORD, d);
      csr_write(CSR_NUM_PERMS, p);
   endtask

   task automatic random_item();
      int unsigned       span;
      int unsigned       pick;
      int unsigned       tries;
      logic              rtype;
      logic [SLOT_W-1:0] slot;
      logic [LABEL_W-1:0] lab;
      span  = (cfg_perms > DEF_MAX_PERMS) ? DEF_MAX_PERMS : cfg_perms;
      pick  = $urandom_range(0, 99);
      lab   = LABEL_W'($urandom_range(0, 15));
      rtype = REQ_WRITE;
      slot  = SLOT_W'($urandom_range(0, 255));
      if (span == 0) begin
         rtype = 1'($urandom_range(0, 1));
      end else if (pick < 80) begin
         if (pick >= 55) begin
            for (tries = 0; tries < 8 && rtype == REQ_WRITE; tries++) begin
               slot = SLOT_W'($urandom_range(0, span - 1));
               if (readable(slot)) rtype = REQ_READ;
            end
         end
         if (rtype == REQ_WRITE) begin
            if (labels_written == 0 || !slot_ok(stream_slot))
               stream_slot = SLOT_W'($urandom_range(0, span - 1));
            slot = stream_slot;
         end
      end else if (pick >= 90) begin
         // read of an unwritten slot is not allowed, so it becomes a stray write
         if (!slot_ok(slot) || readable(slot)) rtype = REQ_READ;
      end
      send_req(rtype, slot, lab, 1'b0, '0);
   endtask

   initial begin : stimulus
      int unsigned i;
      int unsigned ph;
      int unsigned plen;
      int unsigned rand_count;
      for (i = 0; i < STORE_DEPTH; i++) begin
         packed_mem[i]  = '0;
         written_mem[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cfg_row(CSR_NUM_PERMS, 9'd1);
      req_row(REQ_WRITE, 8'd255, 4'd15, 1'b1, mk_word(0, 0, 1'b1, STAT_BAD_SLOT));
      req_row(REQ_READ,  8'd1,   4'd0,  1'b1, mk_word(0, 0, 1'b1, STAT_BAD_SLOT));
      cfg_row(CSR_NUM_LABELS, 9'd1);
      req_row(REQ_WRITE, 8'd0, 4'd15, 1'b1, mk_word(0, 0, 1'b1, STAT_WRITE_DONE));
      req_row(REQ_READ,  8'd0, 4'd0,  1'b0, '0);
      cfg_row(CSR_NUM_CLASSES, 9'd16);
      cfg_row(CSR_DIGITS_PER_WORD, 9'd8);
      cfg_row(CSR_NUM_LABELS, 9'd2);
      cfg_row(CSR_NUM_PERMS, 9'd256);
      req_row(REQ_WRITE, 8'd255, 4'd0,  1'b0, '0);
      req_row(REQ_WRITE, 8'd255, 4'd15, 1'b1, mk_word(0, 1, 1'b1, STAT_WRITE_DONE));
      req_row(REQ_READ,  8'd255, 4'd0,  1'b0, '0);
      // zero registers fall back to their minimum
      cfg_row(CSR_NUM_CLASSES, 9'd0);
      cfg_row(CSR_DIGITS_PER_WORD, 9'd0);
      cfg_row(CSR_NUM_LABELS, 9'd0);
      req_row(REQ_WRITE, 8'd128, 4'd9, 1'b1, mk_word(0, 0, 1'b1, STAT_WRITE_DONE));
      req_row(REQ_READ,  8'd128, 4'd0, 1'b0, '0);
      // slot change in the middle of a stream
      cfg_row(CSR_NUM_CLASSES, 9'd16);
      cfg_row(CSR_DIGITS_PER_WORD, 9'd1);
      cfg_row(CSR_NUM_LABELS, 9'd2);
      req_row(REQ_WRITE, 8'd3, 4'd5,  1'b0, '0);
      req_row(REQ_WRITE, 8'd3, 4'd10, 1'b1, mk_word(0, 1, 1'b1, STAT_WRITE_DONE));
      req_row(REQ_WRITE, 8'd7, 4'd12, 1'b0, '0);
      req_row(REQ_WRITE, 8'd7, 4'd3,  1'b1, mk_word(0, 1, 1'b1, STAT_WRITE_DONE));
      req_row(REQ_WRITE, 8'd3, 4'd15, 1'b0, '0);
      req_row(REQ_WRITE, 8'd7, 4'd1,  1'b1, mk_word(0, 1, 1'b1, STAT_WRITE_DONE));
      req_row(REQ_READ,  8'd3, 4'd0,  1'b0, '0);
      req_row(REQ_READ,  8'd7, 4'd0,  1'b0, '0);

      for (i = 0; i < script.size(); i++) begin
         if (script[i].is_cfg) begin
            wait_idle();
            csr_write(script[i].idx, script[i].data);
         end else begin
            send_req(script[i].rtype, script[i].slot, script[i].lab, script[i].typed,
                     script[i].want);
         end
      end

      ph         = 0;
      rand_count = 0;
      while (rand_count < RAND_ITEMS) begin
         wait_idle();
         phase_config(ph);
         plen = $urandom_range(30, 70);
         for (i = 0; i < plen && rand_count < RAND_ITEMS; i++) begin
            calm = (rand_count >= 200 && rand_count < 320);
            if (rand_count % 150 == 75) begin
               // drain every outstanding word before going on
               req_valid <= 1'b0;
               while (expected_words.size() != 0) @(posedge clock);
               @(posedge clock);
            end
            random_item();
            rand_count++;
         end
         ph++;
      end
      calm = 1'b0;
      wait_idle();

      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/bkls_pkg.sv
sv/base_k_label_pack_store.sv
verif/tb_base_k_label_pack_store.sv
